// ----- rtl/aip_pkg.sv -----
// ----------------------------------------------------------------------------
// aip_pkg
// Types, codes and character helpers shared by the ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

  localparam int unsigned MAX_LEN = 1023;
  localparam int unsigned POS_W   = $clog2(MAX_LEN + 1);

  // parse phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LEAD   = 2'd1;
  localparam logic [1:0] PH_PREFIX = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  // base_mode codes
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [4:0] NO_DIGIT  = 5'd16;
  localparam logic [4:0] LIM_OCT   = 5'd21;
  localparam logic [4:0] LIM_DEC   = 5'd19;
  localparam logic [4:0] LIM_HEX   = 5'd16;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
    logic       end_mark;
  } aip_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
    logic [9:0]         consumed;
  } aip_out_t;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] d;
    d = NO_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) d = 5'(c - CH_ZERO);
    else if (c >= CH_LA && c <= CH_LF) d = 5'(c - CH_LA + 8'd10);
    else if (c >= CH_UA && c <= CH_UF) d = 5'(c - CH_UA + 8'd10);
    return d;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

// ----- rtl/ascii_integer_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Streams ASCII characters and returns the signed 64-bit value of each string.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one character a request, with start_req on the first
//   character of a string and end_mark on the last. A request is taken at a
//   clock edge with in_valid high and in_stall low.
//   out_data gives value, status and consumed length once per string, taken
//   at an edge with out_valid high and out_stall low.
//   cfg_data sets the number base (0 octal, 1 decimal, 2 hex); cfg_ready is
//   always high, write only while no string is in flight.
// Timing:
//   one character per cycle sustained while out_stall holds no result; a
//   character is parsed while it sits in the input register, and its result
//   is registered into out_data as that character leaves the register. The
//   per-character step (shift-add by ten plus range compare) sets the cycle.
// Reset (rst_n low, synchronous): both channels empty, parser idle, base
//   decimal. When out_stall holds a result, the input register still takes
//   one more request and then in_stall rises until the result leaves.
// ----------------------------------------------------------------------------
module ascii_integer_parser
  import aip_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  aip_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output aip_out_t out_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic [1:0] cfg_data
);

  logic             in_vld_r, in_vld_nxt;
  aip_in_t          in_buf_r;
  logic             out_vld_r, out_vld_nxt;
  aip_out_t         out_buf_r;
  logic [1:0]       base_r;
  logic [1:0]       phase_r, phase_nxt;
  logic [63:0]      acc_r, acc_nxt;
  logic [4:0]       dc_r, dc_nxt;
  logic             neg_r, neg_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             zp_r, zp_nxt;
  logic             adv;
  logic             emit;
  aip_out_t         res;

  assign adv       = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_buf_r;

  // one character step
  always_comb begin
    logic [7:0]  c;
    logic        took;
    logic [4:0]  d;
    logic [4:0]  lim;
    logic [67:0] prod;

    c         = in_buf_r.ch;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    dc_nxt    = dc_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    zp_nxt    = zp_r;
    emit      = 1'b0;
    took      = 1'b0;
    res       = '0;
    d         = NO_DIGIT;
    lim       = LIM_HEX;
    prod      = '0;

    if (in_buf_r.start_req) begin
      phase_nxt = PH_LEAD;
      acc_nxt   = '0;
      dc_nxt    = '0;
      neg_nxt   = 1'b0;
      pos_nxt   = '0;
      zp_nxt    = 1'b0;
    end

    if (phase_nxt != PH_IDLE) begin
      if (phase_nxt == PH_LEAD) begin
        if (is_space(c)) begin
          took = 1'b1;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg_nxt   = (c == CH_MINUS);
          phase_nxt = PH_PREFIX;
          took      = 1'b1;
        end else if (hex_value(c) == NO_DIGIT) begin
          emit       = 1'b1;
          res.status = ST_INVALID;
        end else begin
          phase_nxt = PH_PREFIX;
        end
        if (took && pos_nxt < POS_W'(MAX_LEN)) pos_nxt = pos_nxt + 1'b1;
      end

      if (!took && !emit && phase_nxt == PH_PREFIX) begin
        if (zp_nxt) begin
          zp_nxt    = 1'b0;
          phase_nxt = PH_DIGITS;
          if (c == CH_LX || c == CH_UX) begin
            took = 1'b1;
          end else begin
            dc_nxt  = 5'd1;
            acc_nxt = '0;
          end
        end else if (c == CH_ZERO && base_r == BASE_OCT) begin
          phase_nxt = PH_DIGITS;
          took      = 1'b1;
        end else if (c == CH_ZERO && base_r == BASE_HEX) begin
          zp_nxt = 1'b1;
          took   = 1'b1;
        end else begin
          phase_nxt = PH_DIGITS;
        end
        if (took && pos_nxt < POS_W'(MAX_LEN)) pos_nxt = pos_nxt + 1'b1;
      end

      if (!took && !emit) begin
        d = hex_value(c);
        case (base_r)
          BASE_OCT: begin
            lim = LIM_OCT;
            if (d >= 5'd8) d = NO_DIGIT;
          end
          BASE_DEC: begin
            lim = LIM_DEC;
            if (d >= 5'd10) d = NO_DIGIT;
          end
          BASE_HEX: lim = LIM_HEX;
          default:  d = NO_DIGIT;
        endcase
        prod = ({4'd0, acc_nxt} << 3) + ({4'd0, acc_nxt} << 1) + 68'(d);
        if (d == NO_DIGIT) begin
          emit         = 1'b1;
          res.consumed = 10'(pos_nxt);
          if (dc_nxt == '0) begin
            res.status = ST_INVALID;
          end else begin
            res.value = neg_nxt ? -acc_nxt : acc_nxt;
          end
        end else if (dc_nxt >= lim) begin
          emit       = 1'b1;
          res.status = ST_RANGE;
        end else if (base_r == BASE_DEC && prod > 68'(POS_MAX)) begin
          emit       = 1'b1;
          res.status = ST_RANGE;
        end else begin
          if (base_r == BASE_OCT) acc_nxt = {acc_nxt[60:0], d[2:0]};
          else if (base_r == BASE_HEX) acc_nxt = {acc_nxt[59:0], d[3:0]};
          else acc_nxt = prod[63:0];
          dc_nxt = dc_nxt + 1'b1;
          if (pos_nxt < POS_W'(MAX_LEN)) pos_nxt = pos_nxt + 1'b1;
        end
      end

      // end of string closes the number
      if (!emit && in_buf_r.end_mark) begin
        emit = 1'b1;
        if (phase_nxt == PH_LEAD) begin
          res.status = ST_INVALID;
        end else begin
          // a lone hex 0 counts as the digit zero
          if (zp_nxt) begin
            dc_nxt  = 5'd1;
            acc_nxt = '0;
          end
          res.consumed = 10'(pos_nxt);
          if (dc_nxt == '0) begin
            res.status = ST_INVALID;
          end else begin
            res.value = neg_nxt ? -acc_nxt : acc_nxt;
          end
        end
      end

      if (emit) begin
        phase_nxt = PH_IDLE;
        zp_nxt    = 1'b0;
      end
    end
  end

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && !in_stall) in_vld_nxt = 1'b1;
    else if (adv) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (adv) out_vld_nxt = in_vld_r && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      base_r    <= BASE_DEC;
      phase_r   <= PH_IDLE;
      acc_r     <= '0;
      dc_r      <= '0;
      neg_r     <= 1'b0;
      pos_r     <= '0;
      zp_r      <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) base_r <= cfg_data;
      if (in_vld_r && adv) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        dc_r    <= dc_nxt;
        neg_r   <= neg_nxt;
        pos_r   <= pos_nxt;
        zp_r    <= zp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_buf_r <= in_data;
    if (in_vld_r && adv && emit) out_buf_r <= res;
  end

`ifndef SYNTH
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && adv && emit) |=> (phase_r == PH_IDLE && !zp_r))
    else $error("parser not idle after a result");

  a_zero_wait_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    zp_r |-> (phase_r == PH_PREFIX))
    else $error("hex zero pending outside prefix phase");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dc_r <= LIM_OCT)
    else $error("digit count beyond the longest base limit");

  a_range_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_buf_r.status == ST_RANGE) |->
      (out_buf_r.value == '0 && out_buf_r.consumed == '0))
    else $error("range result carries a value or length");
`endif

endmodule
